// ===== hw/rtl/kwl_pkg.sv =====
// kwl_pkg: shared constants, types and register codes for the k-weighted loudness meter
// used by every module under hw/rtl
`default_nettype none
package kwl_pkg;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 28;
    localparam int SUM_BITS       = 58;
    localparam int CNT_BITS       = 25;
    localparam int ACC_BITS       = 64;
    localparam int NUM_REGS       = 8;
    localparam int ADDR_BITS      = 5;
    localparam logic [CNT_BITS-1:0] MAX_PAIRS = 25'd16777216;

    localparam logic [2:0] REG_SHELF_NUM0 = 3'd0;
    localparam logic [2:0] REG_SHELF_NUM1 = 3'd1;
    localparam logic [2:0] REG_SHELF_NUM2 = 3'd2;
    localparam logic [2:0] REG_SHELF_DEN1 = 3'd3;
    localparam logic [2:0] REG_SHELF_DEN2 = 3'd4;
    localparam logic [2:0] REG_HP_GAIN    = 3'd5;
    localparam logic [2:0] REG_HP_DEN1    = 3'd6;
    localparam logic [2:0] REG_HP_DEN2    = 3'd7;

    // multiply-accumulate operand selects
    localparam logic [3:0] OP_X0  = 4'd0;  // current input
    localparam logic [3:0] OP_X1  = 4'd1;
    localparam logic [3:0] OP_X2  = 4'd2;
    localparam logic [3:0] OP_S0  = 4'd3;  // shelf output just formed
    localparam logic [3:0] OP_S1  = 4'd4;
    localparam logic [3:0] OP_S2  = 4'd5;
    localparam logic [3:0] OP_H1  = 4'd6;
    localparam logic [3:0] OP_H2  = 4'd7;
    localparam logic [3:0] OP_SQ  = 4'd8;  // square of high-pass output

    typedef logic signed [COEF_BITS-1:0] t_coef;
    typedef logic signed [SAMPLE_BITS-1:0] t_smp;

    typedef struct packed {
        logic       load;      // capture input pair, clear accumulator
        logic       mac;       // accumulate product
        logic       sub;       // subtract instead of add
        logic       dbl;       // product times two
        logic [3:0] op;
        logic [2:0] coef;
        logic       chan;
        logic       fin_s;     // finish shelf output
        logic       fin_h;     // finish high-pass output and shift history
        logic       integ;     // add energy, count pair
        logic       div_start;
        logic       sqrt_start;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic div_busy;
        logic sqrt_busy;
    } t_status;
endpackage
`default_nettype wire

// ===== hw/rtl/kwl_ctrl.sv =====
// kwl_ctrl: sequencer for the shared multiplier, division and square root
// depends on kwl_pkg
`default_nettype none
module kwl_ctrl import kwl_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    output logic        o_valid,
    input  wire         i_ready,
    input  t_status     i_status,
    output t_cmd        o_cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_MEAN = 3'd5;

    // both squares are in the energy register by this step
    localparam logic [4:0] STEP_INTEG = 5'd23;

    logic [2:0] r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_wait, n_wait;

    // one channel: 3 shelf ff, 2 shelf fb, 3 hp ff, 2 hp fb, then an idle step
    // while the high-pass output lands; the new shelf output is registered in the
    // cycle after its finish step, so it is the last hp ff operand
    function automatic t_cmd step_cmd(input logic [4:0] s);
        t_cmd c;
        logic [3:0] k;
        c = '0;
        c.chan = (s >= 5'd11);
        k = (s >= 5'd11) ? 4'(s - 5'd11) : s[3:0];
        c.mac = 1'b1;
        case (k)
            4'd0:  begin c.op = OP_X0; c.coef = REG_SHELF_NUM0; end
            4'd1:  begin c.op = OP_X1; c.coef = REG_SHELF_NUM1; end
            4'd2:  begin c.op = OP_X2; c.coef = REG_SHELF_NUM2; end
            4'd3:  begin c.op = OP_S1; c.coef = REG_SHELF_DEN1; c.sub = 1'b1; end
            4'd4:  begin
                c.op = OP_S2; c.coef = REG_SHELF_DEN2; c.sub = 1'b1; c.fin_s = 1'b1;
            end
            4'd5:  begin c.op = OP_S1; c.coef = REG_HP_GAIN; c.sub = 1'b1; c.dbl = 1'b1; end
            4'd6:  begin c.op = OP_S2; c.coef = REG_HP_GAIN; end
            4'd7:  begin c.op = OP_S0; c.coef = REG_HP_GAIN; end
            4'd8:  begin c.op = OP_H1; c.coef = REG_HP_DEN1; c.sub = 1'b1; end
            4'd9:  begin
                c.op = OP_H2; c.coef = REG_HP_DEN2; c.sub = 1'b1; c.fin_h = 1'b1;
            end
            4'd10: begin c.op = OP_SQ; c.mac = 1'b0; end
            default: c.mac = 1'b0;
        endcase
        return c;
    endfunction

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_wait  = 1'b0;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                o_cmd = step_cmd(r_step);
                if (r_step == STEP_INTEG) begin
                    o_cmd.integ = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_MEAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            ST_MEAN: begin
                // sum and count now include the last pair
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV;
                n_wait  = 1'b1;
            end
            ST_DIV: begin
                if (!r_wait && !i_status.div_busy) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = ST_SQRT;
                    n_wait  = 1'b1;
                end
            end
            ST_SQRT: begin
                if (!r_wait && !i_status.sqrt_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_wait  <= n_wait;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/kwl_div.sv =====
// kwl_div: radix-2 restoring divider for the mean energy, one quotient bit a cycle
// depends on kwl_pkg
`default_nettype none
module kwl_div import kwl_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire [SUM_BITS-1:0]  i_num,
    input  wire [CNT_BITS:0]    i_den,
    output logic                o_busy,
    output logic [SUM_BITS-1:0] o_quo
);
    logic [5:0]           r_cnt;
    logic                 r_busy;
    logic [SUM_BITS-1:0]  r_q;
    logic [CNT_BITS+1:0]  r_rem;
    logic [CNT_BITS:0]    r_den;
    logic [CNT_BITS+1:0]  w_trial;

    assign w_trial = {r_rem[CNT_BITS:0], r_q[SUM_BITS-1]};
    assign o_busy  = r_busy;
    assign o_quo   = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'(SUM_BITS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) r_busy <= 1'b0;
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= w_trial - {1'b0, r_den};
                r_q   <= {r_q[SUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[SUM_BITS-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/kwl_sqrt.sv =====
// kwl_sqrt: bit-pair integer square root, one result bit a cycle
// depends on kwl_pkg
`default_nettype none
module kwl_sqrt import kwl_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire [SUM_BITS-1:0]  i_val,
    output logic                o_busy,
    output logic [SAMPLE_BITS-1:0] o_root
);
    localparam int RB = SUM_BITS / 2;  // 29 root bits
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic [SUM_BITS-1:0] r_v;
    logic [RB:0]       r_r;
    logic [RB+2:0]     r_rem;
    logic [RB+2:0]     w_trial, w_sub;

    assign w_trial = {r_rem[RB:0], r_v[SUM_BITS-1:SUM_BITS-2]};
    assign w_sub   = {r_r, 2'b01};
    assign o_busy  = r_busy;
    // saturate to the 24-bit field
    assign o_root  = (|r_r[RB:SAMPLE_BITS]) ? {SAMPLE_BITS{1'b1}} : r_r[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(RB - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) r_busy <= 1'b0;
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_v <= {r_v[SUM_BITS-3:0], 2'b00};
            if (w_trial >= w_sub) begin
                r_rem <= w_trial - w_sub;
                r_r   <= {r_r[RB-1:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_r   <= {r_r[RB-1:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/kwl_datapath.sv =====
// kwl_datapath: coefficient registers, filter history, shared multiplier and energy sum
// depends on kwl_pkg, kwl_div, kwl_sqrt
`default_nettype none
module kwl_datapath import kwl_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  wire [SAMPLE_BITS-1:0] i_left_sample,
    input  wire [SAMPLE_BITS-1:0] i_right_sample,
    input  wire                  i_last,
    input  wire                  i_cfg_we,
    input  wire [2:0]            i_cfg_idx,
    input  wire [COEF_BITS-1:0]  i_cfg_data,
    output logic [COEF_BITS-1:0] o_cfg_rdata,
    output logic [SAMPLE_BITS-1:0] o_loudness_rms,
    output logic [CNT_BITS-1:0]  o_sample_count,
    output logic                 o_count_saturated
);
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    t_coef r_coef [NUM_REGS];
    t_smp  r_x [2];       // current inputs
    t_smp  r_x1 [2], r_x2 [2], r_s1 [2], r_s2 [2], r_h1 [2], r_h2 [2];
    t_smp  r_s0;          // shelf output of the channel in flight
    logic  r_last;
    logic signed [ACC_BITS-1:0] r_acc;
    logic signed [ACC_BITS-1:0] r_prod;
    logic  r_prod_v, r_prod_sub;
    logic  r_fin_s, r_fin_h, r_fin_chan, r_sq;
    logic [SUM_BITS-1:0] r_sum;
    logic [CNT_BITS-1:0] r_cnt;
    logic  r_sat;
    t_smp  r_h0 [2];

    t_coef w_c;
    t_smp  w_o;
    logic signed [ACC_BITS-1:0] w_p, w_acc, w_sh;
    t_smp  w_y;
    t_smp  w_hsel;
    logic signed [2*SAMPLE_BITS-1:0] w_hext;
    logic [2*SAMPLE_BITS-1:0] w_sq;
    logic [SUM_BITS-1:0] w_mean;
    logic [SUM_BITS-1:0] w_quo;
    logic  w_dbusy, w_sbusy;

    assign o_cfg_rdata = r_coef[i_cfg_idx];
    assign w_c = r_coef[i_cmd.coef];

    always_comb begin
        case (i_cmd.op)
            OP_X0:   w_o = r_x[i_cmd.chan];
            OP_X1:   w_o = r_x1[i_cmd.chan];
            OP_X2:   w_o = r_x2[i_cmd.chan];
            OP_S0:   w_o = r_s0;
            OP_S1:   w_o = r_s1[i_cmd.chan];
            OP_S2:   w_o = r_s2[i_cmd.chan];
            OP_H1:   w_o = r_h1[i_cmd.chan];
            OP_H2:   w_o = r_h2[i_cmd.chan];
            default: w_o = r_x[i_cmd.chan];
        endcase
    end

    assign w_p = ACC_BITS'(w_c) * ACC_BITS'(w_o);

    // accumulator including the product now arriving
    always_comb begin
        w_acc = r_acc;
        if (r_prod_v) w_acc = r_prod_sub ? r_acc - r_prod : r_acc + r_prod;
    end
    assign w_sh = w_acc >>> COEF_FRAC_BITS;
    assign w_y  = (w_sh > ACC_BITS'(SMAX)) ? SMAX :
                  (w_sh < ACC_BITS'(SMIN)) ? SMIN : w_sh[SAMPLE_BITS-1:0];
    // square of the channel output, kept as 32 fraction bits of full scale
    assign w_hsel = r_h0[r_fin_chan];
    assign w_hext = {{SAMPLE_BITS{w_hsel[SAMPLE_BITS-1]}}, w_hsel};
    assign w_sq   = w_hext * w_hext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= 32'sd409205693;
            r_coef[1] <= -32'sd695441104;
            r_coef[2] <= 32'sd302440861;
            r_coef[3] <= -32'sd435858650;
            r_coef[4] <= 32'sd183623274;
            r_coef[5] <= 32'sd266984025;
            r_coef[6] <= -32'sd533964025;
            r_coef[7] <= 32'sd265536353;
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
            r_fin_s  <= 1'b0;
            r_fin_h  <= 1'b0;
            r_sq     <= 1'b0;
        end else begin
            r_prod_v <= i_cmd.mac;
            r_fin_s  <= i_cmd.fin_s;
            r_fin_h  <= i_cmd.fin_h;
            // high-pass output has been written to r_h0 by r_fin_h when r_sq follows it
            r_sq     <= r_fin_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= i_cmd.dbl ? (w_p <<< 1) : w_p;
        r_prod_sub <= i_cmd.sub;
        r_fin_chan <= i_cmd.chan;
        if (i_cmd.load) begin
            r_x[0] <= t_smp'(i_left_sample);
            r_x[1] <= t_smp'(i_right_sample);
            r_last <= i_last;
        end
        if (i_cmd.load || r_fin_s || r_fin_h) r_acc <= '0;
        else r_acc <= w_acc;
        if (r_fin_s) r_s0 <= w_y;
        if (r_fin_h) begin
            r_h0[r_fin_chan] <= w_y;
            r_x2[r_fin_chan] <= r_x1[r_fin_chan];
            r_x1[r_fin_chan] <= r_x[r_fin_chan];
            r_s2[r_fin_chan] <= r_s1[r_fin_chan];
            r_s1[r_fin_chan] <= r_s0;
            r_h2[r_fin_chan] <= r_h1[r_fin_chan];
            r_h1[r_fin_chan] <= w_y;
        end
        if (i_cmd.clear) begin
            for (int i = 0; i < 2; i++) begin
                r_x1[i] <= '0; r_x2[i] <= '0; r_s1[i] <= '0;
                r_s2[i] <= '0; r_h1[i] <= '0; r_h2[i] <= '0;
            end
        end
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_x1[i] <= '0; r_x2[i] <= '0; r_s1[i] <= '0;
                r_s2[i] <= '0; r_h1[i] <= '0; r_h2[i] <= '0;
            end
        end
    end

    // energy: each square is added the cycle after its channel's output lands;
    // integrate once both are in
    logic [SUM_BITS-1:0] r_esum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_sum  <= '0;
            r_cnt  <= '0;
            r_sat  <= 1'b0;
            r_esum <= '0;
        end else begin
            if (r_sq)
                r_esum <= r_esum + SUM_BITS'(w_sq[2*SAMPLE_BITS-1:2*(SAMPLE_BITS-1)-32]);
            if (i_cmd.integ) begin
                r_esum <= '0;
                if (r_cnt < MAX_PAIRS) begin
                    r_sum <= r_sum + r_esum;
                    r_cnt <= r_cnt + CNT_BITS'(1);
                end else begin
                    r_sat <= 1'b1;
                end
            end
        end
    end

    kwl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_sum),
        .i_den   ({r_cnt, 1'b0}),
        .o_busy  (w_dbusy),
        .o_quo   (w_quo)
    );

    assign w_mean = w_quo << (2*(SAMPLE_BITS-1) - 32);

    kwl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_val   (w_mean),
        .o_busy  (w_sbusy),
        .o_root  (o_loudness_rms)
    );

    assign o_sample_count    = r_cnt;
    assign o_count_saturated = r_sat;
    assign o_status.last      = r_last;
    assign o_status.div_busy  = w_dbusy;
    assign o_status.sqrt_busy = w_sbusy;
endmodule
`default_nettype wire

// ===== hw/rtl/k_weighted_loudness_meter.sv =====
// k_weighted_loudness_meter: top level, APB register port and the two halves
// depends on kwl_pkg, kwl_ctrl, kwl_datapath
`default_nettype none
// Each stereo pair takes a load in the idle state and 24 sequencer steps: ten
// multiply-accumulates per channel on the single shared 32x24 multiplier, one
// idle step per channel while its output lands, and two steps to add both
// squares (from a separate 24x24 squarer) to the energy sum. The pair marked
// last then passes through a step to start the mean division, the division
// itself (one quotient bit a cycle) and the square root before the result is
// offered; the next pair is taken after the result is taken. Coefficients sit at
// byte addresses 0x00..0x1c in the order shelf b0, b1, b2, a1, a2, high-pass
// gain, a1, a2, and are to be written only while the meter is idle; the block
// itself does not enforce this.
module k_weighted_loudness_meter import kwl_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire [SAMPLE_BITS-1:0]  i_left_sample,
    input  wire [SAMPLE_BITS-1:0]  i_right_sample,
    input  wire                    i_last,
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic [SAMPLE_BITS-1:0] o_loudness_rms,
    output logic [CNT_BITS-1:0]    o_sample_count,
    output logic                   o_count_saturated,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [ADDR_BITS-1:0]    paddr,
    input  wire [COEF_BITS-1:0]    pwdata,
    output logic [COEF_BITS-1:0]   prdata,
    output logic                   pready
);
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_we;

    assign pready = 1'b1;
    assign w_we   = psel && penable && pwrite;

    kwl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    kwl_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_left_sample     (i_left_sample),
        .i_right_sample    (i_right_sample),
        .i_last            (i_last),
        .i_cfg_we          (w_we),
        .i_cfg_idx         (paddr[4:2]),
        .i_cfg_data        (pwdata),
        .o_cfg_rdata       (prdata),
        .o_loudness_rms    (o_loudness_rms),
        .o_sample_count    (o_sample_count),
        .o_count_saturated (o_count_saturated)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/kwl_checker.sv =====
// kwl_checker: port-level checks for the loudness meter, bound to the top level
// depends on kwl_pkg
`default_nettype none
module kwl_checker import kwl_pkg::*; (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   o_ready,
    input wire                   o_valid,
    input wire                   i_ready,
    input wire [CNT_BITS-1:0]    o_sample_count,
    input wire                   o_count_saturated,
    input wire                   pready
);
    // no item accepted while a result is offered
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while result pending");
    // a result always covers at least one pair
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample_count != '0)) else $error("empty result");
    // a saturated result only when the count is full
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_count_saturated) |-> (o_sample_count == MAX_PAIRS))
        else $error("flag without full count");
    // result offer and its sample count held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sample_count)))
        else $error("result dropped");
    a_pready: assert property (@(posedge i_clk) pready) else $error("pready low");
endmodule

bind k_weighted_loudness_meter kwl_checker u_kwl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_sample_count    (o_sample_count),
    .o_count_saturated (o_count_saturated),
    .pready            (pready)
);
`default_nettype wire
